// ===== sv/ane_pkg.sv =====
// Package for the ADPCM nibble encoder: types, codes, step and index tables.
package ane_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 6;
    localparam int STEP_W      = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [INDEX_W-1:0] MAX_STEP_INDEX = 6'd48;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_PREDICTOR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STEP_INDEX = 2'd1;

    typedef struct packed {
        logic                       start_block;
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
    } pair_t;

    typedef struct packed {
        logic               valid;
        pair_t              pair;
    } queue_head_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] initial_predictor;
        logic [INDEX_W-1:0]         initial_step_index;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_QUANT,
        ST_UPDATE
    } back_state_t;

    function automatic logic [STEP_W-1:0] step_size(input logic [INDEX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
            6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
            6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
            6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
            6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
            6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
            6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
            6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
            6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
            6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
            6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
            6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
            6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1408;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    // Index change per magnitude, signed 5 bits
    function automatic logic [4:0] index_shift(input logic [2:0] q);
        logic [4:0] d;
        case (q)
            3'd4:    d = 5'd2;
            3'd5:    d = 5'd4;
            3'd6:    d = 5'd6;
            3'd7:    d = 5'd8;
            default: d = 5'b11111;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/ane_pair_if.sv =====
// Sample pair channel: valid, ready and one pair of PCM samples.
interface ane_pair_if;
    import ane_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       start_block;
    logic signed [SAMPLE_W-1:0] first_sample;
    logic signed [SAMPLE_W-1:0] second_sample;

    modport source (output valid, output start_block, output first_sample,
                    output second_sample, input ready);
    modport sink   (input valid, input start_block, input first_sample,
                    input second_sample, output ready);
endinterface

// ===== sv/ane_code_if.sv =====
// Code byte channel: valid, ready and two packed ADPCM nibbles.
interface ane_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_codes;

    modport source (output valid, output packed_codes, input ready);
    modport sink   (input valid, input packed_codes, output ready);
endinterface

// ===== sv/ane_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and data.
interface ane_cfg_if;
    import ane_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ane_front.sv =====
// Front end: configuration registers and the two-entry pair queue.
module ane_front (
    input  logic               clk,
    input  logic               rst_n,
    ane_cfg_if.sink            cfg,
    ane_pair_if.sink           samples,
    output ane_pkg::cfg_t      cfg_regs,
    output ane_pkg::queue_head_t head,
    input  logic               pop
);
    import ane_pkg::*;

    cfg_t       cfg_reg;
    pair_t      slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    pair_t      in_pair;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push          = samples.valid && samples.ready;

    assign in_pair.start_block   = samples.start_block;
    assign in_pair.first_sample  = samples.first_sample;
    assign in_pair.second_sample = samples.second_sample;

    assign cfg_regs   = cfg_reg;
    assign head.valid = (count_reg != 2'd0);
    assign head.pair  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INITIAL_PREDICTOR:  cfg_reg.initial_predictor  <= cfg.data;
                REG_INITIAL_STEP_INDEX: cfg_reg.initial_step_index <= cfg.data[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/ane_back.sv =====
// Back end: per-sample quantize sequencer, predictor state and output register.
module ane_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ane_pkg::cfg_t        cfg_regs,
    input  ane_pkg::queue_head_t head,
    output logic                 pop,
    ane_code_if.source           codes
);
    import ane_pkg::*;

    back_state_t         state_reg, state_next;
    logic [SAMPLE_W-1:0] pred_reg, pred_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    pair_t               pair_reg, pair_next;
    logic                second_reg, second_next;
    logic                sign_reg, sign_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [2:0]          q_reg, q_next;
    logic [3:0]          hi_reg, hi_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_code_reg, out_code_next;

    logic [SAMPLE_W-1:0] sample;
    logic [16:0]         diff;
    logic [16:0]         neg_diff;
    logic [16:0]         rounded;
    logic [13:0]         step14;
    logic [6:0]          hit;
    logic [13:0]         prod;
    logic [17:0]         pred_ext;
    logic [17:0]         sum;
    logic [SAMPLE_W-1:0] pred_upd;
    logic [6:0]          ni;
    logic [INDEX_W-1:0]  idx_upd;
    logic [4:0]          shift;
    logic                out_free;

    assign codes.valid        = out_valid_reg;
    assign codes.packed_codes = out_code_reg;
    assign out_free           = !out_valid_reg || codes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pred_reg      <= '0;
            idx_reg       <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pred_reg      <= pred_next;
            idx_reg       <= idx_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg     <= pair_next;
        sign_reg     <= sign_next;
        mag_reg      <= mag_next;
        step_reg     <= step_next;
        q_reg        <= q_next;
        hi_reg       <= hi_next;
        out_code_reg <= out_code_next;
    end

    // Datapath pieces
    always_comb
    begin
        sample   = second_reg ? pair_reg.second_sample : pair_reg.first_sample;
        diff     = {sample[15], sample} - {pred_reg[15], pred_reg};
        neg_diff = 17'd0 - diff;

        rounded = {1'b0, mag_reg} + {7'd0, step_reg[STEP_W-1:1]};
        step14  = {3'b000, step_reg};
        for (int k = 1; k <= 7; k++)
        begin
            hit[k-1] = (rounded >= {3'b000, step14 * 14'(k)});
        end

        prod     = step14 * {11'd0, q_reg};
        pred_ext = {{2{pred_reg[15]}}, pred_reg};
        sum      = sign_reg ? (pred_ext - {4'd0, prod}) : (pred_ext + {4'd0, prod});
        if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111)
        begin
            pred_upd = sum[15:0];
        end
        else
        begin
            pred_upd = sum[17] ? 16'h8000 : 16'h7FFF;
        end

        shift = index_shift(q_reg);
        ni    = {1'b0, idx_reg} + {{2{shift[4]}}, shift};
        if (ni[6])
        begin
            idx_upd = '0;
        end
        else if (ni[5:0] > MAX_STEP_INDEX)
        begin
            idx_upd = MAX_STEP_INDEX;
        end
        else
        begin
            idx_upd = ni[5:0];
        end
    end

    // Sequencer: pop, then diff / quantize / update for each sample
    always_comb
    begin
        state_next     = state_reg;
        pred_next      = pred_reg;
        idx_next       = idx_reg;
        pair_next      = pair_reg;
        second_next    = second_reg;
        sign_next      = sign_reg;
        mag_next       = mag_reg;
        step_next      = step_reg;
        q_next         = q_reg;
        hi_next        = hi_reg;
        out_code_next  = out_code_reg;
        out_valid_next = out_valid_reg && !codes.ready;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    pair_next   = head.pair;
                    second_next = 1'b0;
                    if (head.pair.start_block)
                    begin
                        pred_next = cfg_regs.initial_predictor;
                        idx_next  = (cfg_regs.initial_step_index > MAX_STEP_INDEX)
                                    ? MAX_STEP_INDEX : cfg_regs.initial_step_index;
                    end
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                sign_next  = diff[16];
                mag_next   = diff[16] ? neg_diff[15:0] : diff[15:0];
                step_next  = step_size(idx_reg);
                state_next = ST_QUANT;
            end
            ST_QUANT:
            begin
                q_next     = 3'($countones(hit));
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!second_reg)
                begin
                    hi_next     = {sign_reg, q_reg};
                    pred_next   = pred_upd;
                    idx_next    = idx_upd;
                    second_next = 1'b1;
                    state_next  = ST_DIFF;
                end
                else if (out_free)
                begin
                    pred_next      = pred_upd;
                    idx_next       = idx_upd;
                    out_code_next  = {hi_reg, sign_reg, q_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/adpcm_nibble_encoder_top.sv =====
// Top level of the 4-bit ADPCM nibble encoder.
//
// Usage:
//   samples : request of one sample pair (start_block, first_sample,
//             second_sample); accepted when valid and ready are high.
//   codes   : one byte per request, first code in the high nibble; each
//             nibble is sign in bit 3 and magnitude in bits 2..0.
//   cfg     : register writes (index 0 initial predictor, index 1 initial
//             step index); always ready, write only while no request is in
//             flight. Other indexes are dropped.
// Flow:
//   A request lands in a two-entry queue; the back end pops it when idle
//   and steps through difference, quantize and predictor/index update for
//   each sample, first then second. The queue takes new requests while the
//   back end works, but the back end encodes one request at a time and
//   raises codes.valid from its output register.
// Reset: predictor, step index and both registers clear to zero; queue and
//   output register are empty.
// Stall: a held code byte keeps the back end in its final update step; the
//   queue takes up to two more requests before samples.ready drops.
module adpcm_nibble_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    ane_cfg_if.sink     cfg,
    ane_pair_if.sink    samples,
    ane_code_if.source  codes
);
    import ane_pkg::*;

    cfg_t        cfg_regs;
    queue_head_t head;
    logic        pop;

    // Front: configuration registers and request queue
    ane_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .samples  (samples),
        .cfg_regs (cfg_regs),
        .head     (head),
        .pop      (pop)
    );

    // Back: quantizer sequencer and output register
    ane_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .head     (head),
        .pop      (pop),
        .codes    (codes)
    );

    // The back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");

    // A pair takes several cycles, so pops never come back to back
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> !pop)
        else $error("back-to-back pop");

    // An accepted request is visible at the queue head next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> head.valid)
        else $error("accepted request lost");

endmodule
